### hdl/ucdw_pkg.sv
// Shared types and constants for the configuration descriptor walker.
// Depends on nothing; used by usb_config_descriptor_walker.
package ucdw_pkg;

   // Endpoint slots available for capture
   localparam int MAX_ENDPOINTS = 16;
   localparam int EP_CNT_W      = $clog2(MAX_ENDPOINTS + 1);

   // Descriptor type codes and minimum lengths
   localparam logic [7:0] KIND_INTERFACE = 8'd4;
   localparam logic [7:0] KIND_ENDPOINT  = 8'd5;
   localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
   localparam logic [7:0] EP_MIN_LEN     = 8'd7;
   localparam logic [7:0] MIN_DESC_LEN   = 8'd2;

   // Walk status codes
   localparam logic [1:0] STATUS_BUSY      = 2'd0;
   localparam logic [1:0] STATUS_DONE      = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_TOTAL_LENGTH    = 2'd0;
   localparam logic [1:0] CSR_DEVICE_CLASS    = 2'd1;
   localparam logic [1:0] CSR_DEVICE_SUBCLASS = 2'd2;
   localparam logic [1:0] CSR_DEVICE_PROTOCOL = 2'd3;

   typedef struct packed {
      logic [7:0] config_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  interface_number;
      logic [7:0]  current_class;
      logic [7:0]  current_subclass;
      logic [7:0]  current_protocol;
      logic [4:0]  endpoint_count;
      logic        endpoint_captured;
      logic [3:0]  endpoint_slot;
      logic [7:0]  endpoint_address;
      logic [7:0]  endpoint_attributes;
      logic [15:0] endpoint_max_packet;
      logic [7:0]  endpoint_interval;
      logic [1:0]  parse_status;
   } rsp_type;

endpackage

### hdl/usb_config_descriptor_walker.sv
// Top level of the configuration descriptor walker: input register, walk logic,
// result register. Depends on ucdw_pkg.
//
// Usage:
//   Load total_length and the device class/subclass/protocol through the csr_
//   write port while the block is idle, then send the configuration block one
//   byte per req_ transfer, first_byte set on the byte at offset zero.
//   Every byte yields exactly one rsp_ transfer carrying the last interface
//   number, the class triple after the interface override rule, the endpoint
//   count, the endpoint just captured (zeroes when none) and the walk status.
// Each accepted byte passes through the input register, then the result register.
// Throughput: one byte per cycle while the result is not held; the walk is a
//   single combinational pass between the input register and the result
//   register, so each byte sees the state left by the byte before it.
// Stall: the result register holds while it is valid and rsp_stall is high;
//   the input register then takes a byte only while empty, and once it holds
//   one, req_stall stays high until the result is taken.
// Reset: clears the configuration registers, the walk state and both valid
//   flags. Without a first_byte restart the walk starts at offset zero with
//   a zero class triple.
module usb_config_descriptor_walker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ucdw_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ucdw_pkg::rsp_type rsp_payload,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   // Configuration registers
   logic [15:0] total_length_ff;
   logic [7:0]  device_class_ff;
   logic [7:0]  device_subclass_ff;
   logic [7:0]  device_protocol_ff;

   // Pipeline registers
   logic              s1_valid_ff;
   ucdw_pkg::req_type s1_data_ff;
   logic              rsp_valid_ff;
   ucdw_pkg::rsp_type rsp_data_ff;
   ucdw_pkg::rsp_type rsp_data_in;

   // Walk state
   logic [15:0]                   byte_offset_ff, byte_offset_in;
   logic [15:0]                   desc_start_ff, desc_start_in;
   logic [7:0]                    desc_length_ff, desc_length_in;
   logic [7:0]                    desc_kind_ff, desc_kind_in;
   logic [5:0][7:0]               field_buffer_ff, field_buffer_in;
   logic [ucdw_pkg::EP_CNT_W-1:0] stored_eps_ff, stored_eps_in;
   logic [23:0]                   class_triple_ff, class_triple_in;
   logic [7:0]                    last_interface_ff, last_interface_in;
   logic [1:0]                    walk_status_ff, walk_status_in;

   // Walk intermediates
   logic                          restart;
   logic [7:0]                    cur_byte;
   logic [15:0]                   offset_cur;
   logic [15:0]                   start_cur;
   logic [ucdw_pkg::EP_CNT_W-1:0] eps_cur;
   logic [1:0]                    status_cur;
   logic [23:0]                   triple_cur;
   logic [15:0]                   rel;
   logic [15:0]                   desc_end;
   logic                          captured;
   logic [3:0]                    slot;

   logic advance;
   logic fire;

   // Move the result register whenever it is empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff    <= '0;
         device_class_ff    <= '0;
         device_subclass_ff <= '0;
         device_protocol_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            ucdw_pkg::CSR_TOTAL_LENGTH:    total_length_ff    <= csr_wdata;
            ucdw_pkg::CSR_DEVICE_CLASS:    device_class_ff    <= csr_wdata[7:0];
            ucdw_pkg::CSR_DEVICE_SUBCLASS: device_subclass_ff <= csr_wdata[7:0];
            ucdw_pkg::CSR_DEVICE_PROTOCOL: device_protocol_ff <= csr_wdata[7:0];
         endcase
      end
   end

   // Input register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_payload;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Walk state advances once per transfer leaving the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff    <= '0;
         desc_start_ff     <= '0;
         desc_length_ff    <= '0;
         desc_kind_ff      <= '0;
         field_buffer_ff   <= '0;
         stored_eps_ff     <= '0;
         class_triple_ff   <= '0;
         last_interface_ff <= '0;
         walk_status_ff    <= ucdw_pkg::STATUS_BUSY;
      end else if (fire) begin
         byte_offset_ff    <= byte_offset_in;
         desc_start_ff     <= desc_start_in;
         desc_length_ff    <= desc_length_in;
         desc_kind_ff      <= desc_kind_in;
         field_buffer_ff   <= field_buffer_in;
         stored_eps_ff     <= stored_eps_in;
         class_triple_ff   <= class_triple_in;
         last_interface_ff <= last_interface_in;
         walk_status_ff    <= walk_status_in;
      end
   end

   // Walk one byte
   always_comb begin
      restart  = s1_data_ff.first_byte;
      cur_byte = s1_data_ff.config_byte;

      // A restart clears the position, endpoint count and status and reloads the class triple first
      offset_cur = restart ? 16'd0 : byte_offset_ff;
      start_cur  = restart ? 16'd0 : desc_start_ff;
      eps_cur    = restart ? '0 : stored_eps_ff;
      status_cur = restart ? ucdw_pkg::STATUS_BUSY : walk_status_ff;
      triple_cur = restart ? {device_class_ff, device_subclass_ff, device_protocol_ff}
                           : class_triple_ff;

      desc_length_in    = desc_length_ff;
      desc_kind_in      = desc_kind_ff;
      field_buffer_in   = field_buffer_ff;
      last_interface_in = last_interface_ff;
      class_triple_in   = triple_cur;
      stored_eps_in     = eps_cur;
      walk_status_in    = status_cur;
      desc_start_in     = start_cur;
      captured          = 1'b0;
      slot              = '0;
      desc_end          = start_cur + 16'(desc_length_ff);

      // Position within the current descriptor
      rel = offset_cur - start_cur;

      if (status_cur == ucdw_pkg::STATUS_BUSY) begin
         if (rel == 16'd0) begin
            // Descriptor boundary: finish when fewer than two bytes remain
            if ({1'b0, start_cur} + 17'd2 > {1'b0, total_length_ff}) begin
               walk_status_in = ucdw_pkg::STATUS_DONE;
            end else begin
               desc_length_in = cur_byte;
            end
         end else if (rel == 16'd1) begin
            desc_kind_in = cur_byte;
            if (desc_length_ff < ucdw_pkg::MIN_DESC_LEN ||
                {1'b0, start_cur} + {9'd0, desc_length_ff} > {1'b0, total_length_ff}) begin
               walk_status_in = ucdw_pkg::STATUS_MALFORMED;
            end
         end else if (rel < 16'd8) begin
            for (int k = 0; k < 6; k++) begin
               if (rel[2:0] == 3'(k + 2)) begin
                  field_buffer_in[k] = cur_byte;
               end
            end
         end

         // Last byte of the descriptor: act on its type, then step to the next
         if (walk_status_in == ucdw_pkg::STATUS_BUSY && rel != 16'd0 &&
             {1'b0, rel} + 17'd1 == {9'd0, desc_length_ff}) begin
            if (desc_kind_in == ucdw_pkg::KIND_INTERFACE &&
                desc_length_ff >= ucdw_pkg::IFACE_MIN_LEN) begin
               last_interface_in = field_buffer_in[0];
               if (triple_cur[23:16] == 8'd0) begin
                  class_triple_in = {field_buffer_in[3], field_buffer_in[4],
                                     field_buffer_in[5]};
               end
            end else if (desc_kind_in == ucdw_pkg::KIND_ENDPOINT &&
                         desc_length_ff >= ucdw_pkg::EP_MIN_LEN) begin
               // Drop endpoints once every slot is taken
               if ({1'b0, eps_cur} < (ucdw_pkg::EP_CNT_W + 1)'(ucdw_pkg::MAX_ENDPOINTS)) begin
                  captured      = 1'b1;
                  slot          = 4'(eps_cur);
                  stored_eps_in = eps_cur + 1'b1;
               end
            end
            desc_start_in = desc_end;
            if ({1'b0, desc_end} + 17'd2 > {1'b0, total_length_ff}) begin
               walk_status_in = ucdw_pkg::STATUS_DONE;
            end
         end
      end

      // Offset keeps counting past the end and saturates
      byte_offset_in = (offset_cur != 16'hFFFF) ? offset_cur + 16'd1 : offset_cur;

      rsp_data_in.interface_number    = last_interface_in;
      rsp_data_in.current_class       = class_triple_in[23:16];
      rsp_data_in.current_subclass    = class_triple_in[15:8];
      rsp_data_in.current_protocol    = class_triple_in[7:0];
      rsp_data_in.endpoint_count      = 5'(stored_eps_in);
      rsp_data_in.endpoint_captured   = captured;
      rsp_data_in.endpoint_slot       = slot;
      rsp_data_in.endpoint_address    = captured ? field_buffer_in[0] : 8'd0;
      rsp_data_in.endpoint_attributes = captured ? field_buffer_in[1] : 8'd0;
      rsp_data_in.endpoint_max_packet = captured ? {field_buffer_in[3], field_buffer_in[2]}
                                                 : 16'd0;
      rsp_data_in.endpoint_interval   = captured ? field_buffer_in[4] : 8'd0;
      rsp_data_in.parse_status        = walk_status_in;
   end

   // Input side only stalls behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // A captured endpoint never comes with a malformed status
   a_capture_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.endpoint_captured) |->
         (rsp_payload.parse_status != ucdw_pkg::STATUS_MALFORMED))
      else $error("endpoint captured on malformed walk");

   // Count reported with a capture is one past its slot
   a_capture_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.endpoint_captured) |->
         (rsp_payload.endpoint_count[3:0] == rsp_payload.endpoint_slot + 4'd1))
      else $error("endpoint count does not follow slot");

   // A finished walk holds its status until a restart
   a_status_hold: assert property (@(posedge clock) disable iff (reset)
      (walk_status_ff != ucdw_pkg::STATUS_BUSY && !(fire && s1_data_ff.first_byte))
         |=> (walk_status_ff == $past(walk_status_ff)))
      else $error("final walk status changed without restart");

endmodule
